@@ hdl/wpm_pkg.sv @@
`default_nettype none

package wpm_pkg;

    // Default pattern store depth
    localparam int MAX_PATTERN_DEF = 64;

    // Byte width and wildcard codes
    localparam int            CH_W    = 8;
    localparam logic [CH_W-1:0] CH_STAR = 8'd42;
    localparam logic [CH_W-1:0] CH_ANY  = 8'd63;

    // Input kind codes as they arrive on tuser
    localparam int         KIND_W      = 2;
    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_APPEND = 2'd1;
    localparam logic [1:0] KIND_TEXT   = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_APPEND,
        OP_TEXT,
        OP_END
    } op_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t             op;
        logic [CH_W-1:0] ch;
        logic            star;
        logic            any;
    } cmd_t;

endpackage

`default_nettype wire

@@ hdl/wpm_front.sv @@
`default_nettype none

module wpm_front
    import wpm_pkg::*;
(
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CH_W-1:0]   s_tdata,   // [7:0] ch
    input  wire logic [KIND_W-1:0] s_tuser,   // [1:0] kind
    input  wire logic              q_full,
    output logic                   push,
    output cmd_t                   push_cmd
);

    // Take a request whenever the queue has room
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Classify the request and flag wildcard bytes
    always_comb
    begin
        push_cmd.ch   = s_tdata;
        push_cmd.star = (s_tdata == CH_STAR);
        push_cmd.any  = (s_tdata == CH_ANY);
        case (s_tuser)
            KIND_CLEAR:  push_cmd.op = OP_CLEAR;
            KIND_APPEND: push_cmd.op = OP_APPEND;
            KIND_TEXT:   push_cmd.op = OP_TEXT;
            KIND_END:    push_cmd.op = OP_END;
            default:     push_cmd.op = OP_END;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/wpm_queue.sv @@
`default_nettype none

module wpm_queue
    import wpm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      head_valid,
    output cmd_t      head_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/wpm_back.sv @@
`default_nettype none

module wpm_back
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire cmd_t       head_cmd,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] match, [1] overflow, [7:2] zero
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Pattern lanes: byte, wildcard flags, in-use thermometer
    logic [CH_W-1:0]        char_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg;
    logic [MAX_PATTERN-1:0] any_reg;
    logic [MAX_PATTERN-1:0] used_reg, used_next;

    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic [MAX_PATTERN:0]   emp_reg, emp_next;   // empty-text prefix state
    logic [MAX_PATTERN:0]   vec_reg, vec_next;   // prefix match vector

    logic                   out_valid_reg, out_valid_next;
    logic                   out_match_reg, out_match_next;
    logic                   out_ovf_reg, out_ovf_next;

    logic                   store_full;
    logic                   out_free;
    logic                   do_append;
    logic [MAX_PATTERN:0]   emp_app;
    logic [MAX_PATTERN-1:0] used_app;
    logic [MAX_PATTERN-1:0] gen0, prop0;
    logic [MAX_PATTERN-1:0] scan_g, scan_p, step_g, step_p;

    assign store_full = (len_reg == LEN_W'(MAX_PATTERN));
    assign out_free   = !out_valid_reg || m_tready;
    assign pop        = head_valid && ((head_cmd.op != OP_END) || out_free);
    assign do_append  = pop && (head_cmd.op == OP_APPEND) && !store_full;

    // Empty-text state and thermometer after an append at lane len
    always_comb
    begin
        emp_app[0] = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (len_reg == LEN_W'(j))
            begin
                emp_app[j+1] = emp_reg[j] & head_cmd.star;
                used_app[j]  = 1'b1;
            end
            else
            begin
                emp_app[j+1] = emp_reg[j+1];
                used_app[j]  = used_reg[j];
            end
        end
    end

    // Per-lane generate/propagate for one text byte
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (star_reg[j])
            begin
                gen0[j] = used_reg[j] & vec_reg[j+1];
            end
            else
            begin
                gen0[j] = used_reg[j] & vec_reg[j]
                          & (any_reg[j] | (char_reg[j] == head_cmd.ch));
            end
            prop0[j] = used_reg[j] & star_reg[j];
        end
    end

    // Log-depth segmented OR carries matches through runs of stars
    always_comb
    begin
        scan_g = gen0;
        scan_p = prop0;
        step_g = gen0;
        step_p = prop0;
        for (int d = 1; d < MAX_PATTERN; d = d * 2)
        begin
            step_g = scan_g;
            step_p = scan_p;
            for (int j = d; j < MAX_PATTERN; j++)
            begin
                step_g[j] = scan_g[j] | (scan_p[j] & scan_g[j-d]);
                step_p[j] = scan_p[j] & scan_p[j-d];
            end
            scan_g = step_g;
            scan_p = step_p;
        end
    end

    // Execute the head request
    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        used_next      = used_reg;
        emp_next       = emp_reg;
        vec_next       = vec_reg;
        out_match_next = out_match_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop)
        begin
            case (head_cmd.op)
                OP_CLEAR:
                begin
                    len_next  = '0;
                    ovf_next  = 1'b0;
                    used_next = '0;
                    emp_next  = (MAX_PATTERN+1)'(1);
                    vec_next  = (MAX_PATTERN+1)'(1);
                end
                OP_APPEND:
                begin
                    if (store_full)
                    begin
                        ovf_next = 1'b1;
                        vec_next = emp_reg;
                    end
                    else
                    begin
                        len_next  = len_reg + 1'b1;
                        used_next = used_app;
                        emp_next  = emp_app;
                        vec_next  = emp_app;
                    end
                end
                OP_TEXT:
                begin
                    vec_next = {scan_g, 1'b0};
                end
                OP_END:
                begin
                    out_valid_next = 1'b1;
                    out_match_next = vec_reg[len_reg] && !ovf_reg;
                    out_ovf_next   = ovf_reg;
                    vec_next       = emp_reg;
                end
                default:
                begin
                    vec_next = vec_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            used_reg      <= '0;
            emp_reg       <= (MAX_PATTERN+1)'(1);
            vec_reg       <= (MAX_PATTERN+1)'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            used_reg      <= used_next;
            emp_reg       <= emp_next;
            vec_reg       <= vec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Lane writes and result payload
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (do_append && (len_reg == LEN_W'(j)))
            begin
                char_reg[j] <= head_cmd.ch;
                star_reg[j] <= head_cmd.star;
                any_reg[j]  <= head_cmd.any;
            end
        end
        out_match_reg <= out_match_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_ovf_reg, out_match_reg};

    // Lane thermometer tracks the pattern length
    a_used_len: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg) == int'(len_reg))
        else $error("lane thermometer out of step with pattern length");

    // No prefix beyond the pattern can match
    a_vec_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vec_reg & ~{used_reg, 1'b1}) == '0)
        else $error("match bit set beyond pattern length");

    // Clear returns to the empty-pattern state
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_cmd.op == OP_CLEAR) |=>
        (len_reg == '0 && !ovf_reg && vec_reg == (MAX_PATTERN+1)'(1)))
        else $error("clear did not reset pattern state");

    // A held result is never overwritten by a new end of text
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> $stable(out_match_reg) && $stable(out_ovf_reg))
        else $error("stalled result overwritten");

    // Overflow forces no match
    a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_match_reg && out_ovf_reg))
        else $error("match reported with overflow");

endmodule

`default_nettype wire

@@ hdl/wildcard_pattern_matcher.sv @@
// Whole-string wildcard matcher, '?' matches one byte, '*' any run.
// Input stream (s_*): tuser carries the kind (clear pattern, append pattern
// byte, text byte, end of text) and tdata the byte. Output stream (m_*)
// carries one result per end of text: tdata[0] match, tdata[1] overflow.
// Load a pattern with a clear and appends, then stream text bytes and an
// end of text; the match state returns to the pattern's empty-text state
// after each end of text, so texts follow one another with no extra request.
// Throughput: one request per cycle, except while an end of text waits on a
// stalled result; text bytes update every prefix of the pattern at once, the
// depth of the star carry chain being log2(MAX_PATTERN) levels of AND/OR.
// An end of text passes through the request queue and then the match engine,
// whose output register drives the result onto m_tvalid.
// A stalled receiver holds the result in the output register; requests keep
// flowing until the next end of text reaches the engine, then the two-entry
// queue fills and s_tready drops.
// Reset: pattern empty, overflow clear, no result pending.
`default_nettype none

module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [CH_W-1:0]   s_tdata,   // [7:0] ch
    input  wire logic [KIND_W-1:0] s_tuser,   // [1:0] kind
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata    // [0] match, [1] overflow, [7:2] zero
);

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    wpm_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    wpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    wpm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
    import wpm_pkg::*;

    localparam int DEPTH        = MAX_PATTERN_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES  = 20;

    // One request on the input stream
    typedef struct {
        op_t             kind;
        logic [CH_W-1:0] ch;
        bit              drain_first;   // hold until all results are back
    } req_t;

    // Expected end-of-text verdict
    typedef struct {
        logic match;
        logic overflow;
    } verdict_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [CH_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0] s_tuser = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [7:0]      m_tdata;

    req_t     pending[$];
    verdict_t verdicts_due[$];
    req_t     cur_req;
    bit       drain_next = 1'b0;
    int       accepted_cnt = 0;
    int       total_items = 1;
    int       err_cnt = 0;
    int       cycle_cnt = 0;
    int       send_idle_pct;
    int       recv_stall_pct;

    // Matcher state as the testbench sees it
    logic [CH_W-1:0] pat_bytes [DEPTH];
    int              pat_len = 0;
    logic [DEPTH:0]  prefix_ok = {{DEPTH{1'b0}}, 1'b1};
    logic            pat_overflow = 1'b0;

    wildcard_pattern_matcher i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Prefixes that match an empty text: leading run of stars only
    function automatic logic [DEPTH:0] empty_text_prefixes();
        logic [DEPTH:0] v;
        v    = '0;
        v[0] = 1'b1;
        for (int j = 0; j < DEPTH; j++)
            v[j+1] = v[j] && (j < pat_len) && (pat_bytes[j] == CH_STAR);
        return v;
    endfunction

    // Prefix vector after one more text byte
    function automatic logic [DEPTH:0] prefixes_after_byte(logic [CH_W-1:0] c);
        logic [DEPTH:0] nv;
        nv = '0;
        for (int j = 0; j < pat_len; j++)
        begin
            if (pat_bytes[j] == CH_STAR)
                nv[j+1] = prefix_ok[j+1] || nv[j];
            else if (pat_bytes[j] == CH_ANY)
                nv[j+1] = prefix_ok[j];
            else
                nv[j+1] = prefix_ok[j] && (pat_bytes[j] == c);
        end
        return nv;
    endfunction

    // Update the matcher state for an accepted request
    task automatic track_request(req_t r);
        verdict_t v;
        case (r.kind)
            OP_CLEAR:
            begin
                pat_len      = 0;
                pat_overflow = 1'b0;
                prefix_ok    = empty_text_prefixes();
            end
            OP_APPEND:
            begin
                if (pat_len >= DEPTH)
                    pat_overflow = 1'b1;
                else
                begin
                    pat_bytes[pat_len] = r.ch;
                    pat_len++;
                end
                prefix_ok = empty_text_prefixes();
            end
            OP_TEXT:
            begin
                prefix_ok = prefixes_after_byte(r.ch);
            end
            default:
            begin
                v.match    = prefix_ok[pat_len] && !pat_overflow;
                v.overflow = pat_overflow;
                verdicts_due.insert(verdicts_due.size(), v);
                prefix_ok  = empty_text_prefixes();
            end
        endcase
    endtask

    task automatic add_req(op_t k, logic [CH_W-1:0] c);
        req_t r;
        r.kind        = k;
        r.ch          = c;
        r.drain_first = drain_next;
        drain_next    = 1'b0;
        pending.insert(pending.size(), r);
    endtask

    // Mostly letters a/b and wildcards, now and then any byte
    function automatic logic [CH_W-1:0] pick_pattern_byte();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return 8'h61;
        else if (r < 50)
            return 8'h62;
        else if (r < 70)
            return CH_STAR;
        else if (r < 85)
            return CH_ANY;
        return CH_W'($urandom_range(255));
    endfunction

    // Idle rates by test phase
    always_comb
    begin
        if (accepted_cnt < total_items / 3)
        begin
            send_idle_pct  = 9;
            recv_stall_pct = 51;
        end
        else if (accepted_cnt < (2 * total_items) / 3)
        begin
            send_idle_pct  = 51;
            recv_stall_pct = 9;
        end
        else
        begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end
    end

    // Driver: track accepted requests, present the next one
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                track_request(cur_req);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending.size() != 0
                    && !(pending[0].drain_first && verdicts_due.size() != 0)
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_req = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_req.ch;
                    s_tuser  <= cur_req.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, compare results in order
    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual tdata=%h",
                             $time, m_tdata);
                    err_cnt++;
                end
                else
                begin
                    exp_v = verdicts_due.pop_front();
                    if (m_tdata[0] !== exp_v.match)
                    begin
                        $display("%0t: match mismatch, expected %b, actual %b",
                                 $time, exp_v.match, m_tdata[0]);
                        err_cnt++;
                    end
                    if (m_tdata[1] !== exp_v.overflow)
                    begin
                        $display("%0t: overflow mismatch, expected %b, actual %b",
                                 $time, exp_v.overflow, m_tdata[1]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [CH_W-1:0] pat_q[$];
        logic [CH_W-1:0] txt_q[$];
        logic [CH_W-1:0] b;
        int              plen;
        int              seq_no;
        int              pos;
        bit              drain_done;

        for (int i = 0; i < DEPTH; i++)
            pat_bytes[i] = '0;

        // Directed: empty pattern with empty and non-empty text
        add_req(OP_END, 8'h00);
        add_req(OP_TEXT, 8'h61);
        add_req(OP_END, 8'h00);
        // All-star pattern against empty text
        add_req(OP_CLEAR, 8'hFF);
        add_req(OP_APPEND, CH_STAR);
        add_req(OP_APPEND, CH_STAR);
        add_req(OP_END, 8'h00);
        // "**a" against byte extremes then 'a'
        add_req(OP_APPEND, 8'h61);
        add_req(OP_TEXT, 8'h00);
        add_req(OP_TEXT, 8'hFF);
        add_req(OP_TEXT, 8'h61);
        add_req(OP_END, 8'h00);
        // "**a?" one byte short, then pattern edited mid-text
        add_req(OP_APPEND, CH_ANY);
        add_req(OP_TEXT, 8'h61);
        add_req(OP_END, 8'h00);
        add_req(OP_TEXT, 8'h78);
        add_req(OP_APPEND, 8'hFF);
        add_req(OP_TEXT, 8'h61);
        add_req(OP_TEXT, 8'h62);
        add_req(OP_TEXT, 8'hFF);
        add_req(OP_END, 8'h00);
        // Single '?' and single literal zero byte
        add_req(OP_CLEAR, 8'h00);
        add_req(OP_APPEND, CH_ANY);
        add_req(OP_TEXT, 8'h00);
        add_req(OP_END, 8'h00);
        add_req(OP_CLEAR, 8'h00);
        add_req(OP_APPEND, 8'h00);
        add_req(OP_TEXT, 8'h00);
        add_req(OP_END, 8'h00);

        // Random: mostly clean pattern/text sequences, some noise
        seq_no     = 0;
        drain_done = 1'b0;
        while (pending.size() < RANDOM_ITEMS)
        begin
            if (!drain_done && pending.size() > RANDOM_ITEMS / 2)
            begin
                drain_next = 1'b1;
                drain_done = 1'b1;
            end
            if ($urandom_range(99) < 10)
            begin
                repeat ($urandom_range(1, 4))
                    add_req(op_t'($urandom_range(3)), CH_W'($urandom_range(255)));
            end
            else
            begin
                // Overflow needs a full store plus one; force a couple of near-full patterns
                if (seq_no == 5 || seq_no == 30 || $urandom_range(99) < 4)
                    plen = DEPTH - 4 + $urandom_range(6);
                else if ($urandom_range(99) < 12)
                    plen = $urandom_range(9, 20);
                else
                    plen = $urandom_range(8);
                add_req(OP_CLEAR, CH_W'($urandom_range(255)));
                pat_q.delete();
                for (int i = 0; i < plen; i++)
                begin
                    b = pick_pattern_byte();
                    pat_q.insert(pat_q.size(), b);
                    add_req(OP_APPEND, b);
                end
                repeat ($urandom_range(1, 4))
                begin
                    txt_q.delete();
                    if ($urandom_range(99) < 60)
                    begin
                        // Text built to fit the pattern, sometimes spoiled
                        foreach (pat_q[i])
                        begin
                            if (pat_q[i] == CH_STAR)
                                repeat ($urandom_range(3))
                                    txt_q.insert(txt_q.size(),
                                                 CH_W'(8'h61 + $urandom_range(1)));
                            else if (pat_q[i] == CH_ANY)
                                txt_q.insert(txt_q.size(), CH_W'($urandom_range(255)));
                            else
                                txt_q.insert(txt_q.size(), pat_q[i]);
                        end
                        if (txt_q.size() != 0 && $urandom_range(99) < 20)
                        begin
                            pos = $urandom_range(txt_q.size() - 1);
                            txt_q[pos] = CH_W'($urandom_range(255));
                        end
                    end
                    else
                    begin
                        repeat ($urandom_range(8))
                        begin
                            if ($urandom_range(99) < 80)
                                txt_q.insert(txt_q.size(),
                                             CH_W'(8'h61 + $urandom_range(1)));
                            else
                                txt_q.insert(txt_q.size(), CH_W'($urandom_range(255)));
                        end
                    end
                    foreach (txt_q[i])
                        add_req(OP_TEXT, txt_q[i]);
                    add_req(OP_END, CH_W'($urandom_range(255)));
                end
            end
            seq_no++;
        end
        total_items = pending.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all requests, then all results, then a quiet tail
        while (pending.size() != 0 || s_tvalid)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_cnt == 0 && verdicts_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/wpm_pkg.sv
hdl/wpm_front.sv
hdl/wpm_queue.sv
hdl/wpm_back.sv
hdl/wildcard_pattern_matcher.sv
sim/tb_top.sv
